// ===== hw/rtl/gste_pkg.sv =====
// Shared types, widths and constants of the group soft threshold engine.
package gste_pkg;

	// Field widths of the item formats.
	localparam int COEF_W   = 24;
	localparam int THR_W    = 24;
	localparam int FRAC_W   = 16;
	localparam int FACTOR_W = FRAC_W + 1;

	// Shrink factor of exactly one in unsigned 1.16 form.
	localparam logic [FACTOR_W-1:0] ONE_Q16  = FACTOR_W'(1) << FRAC_W;
	localparam logic [FACTOR_W-1:0] ZERO_Q16 = '0;

	// Digit-serial multiplier geometry.
	localparam int MUL_W     = 24;
	localparam int DIGIT_W   = 4;
	localparam int MUL_STEPS = MUL_W / DIGIT_W;

	// Default buffer depth.
	localparam int GROUP_MAX_DEF = 64;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT_GO,
		ST_ROOT,
		ST_DECIDE,
		ST_DIVIDE,
		ST_EMIT_READ,
		ST_EMIT_MUL,
		ST_EMIT_WAIT,
		ST_EMIT_PUSH
	} state_t;

endpackage

// ===== hw/rtl/gste_in_if.sv =====
// Input channel of the engine: one coefficient item with its group end mark.
interface gste_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [gste_pkg::COEF_W-1:0]  coefficient;
	logic                                group_end;

	modport source (output valid, output coefficient, output group_end, input ready);
	modport sink   (input valid, input coefficient, input group_end, output ready);
endinterface

// ===== hw/rtl/gste_out_if.sv =====
// Output channel of the engine: one shrunk element item with its flags.
interface gste_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [gste_pkg::COEF_W-1:0]  shrunk_value;
	logic                                last_of_run;
	logic                                overflow_flag;

	modport source (output valid, output shrunk_value, output last_of_run,
		output overflow_flag, input ready);
	modport sink   (input valid, input shrunk_value, input last_of_run,
		input overflow_flag, output ready);
endinterface

// ===== hw/rtl/gste_digit_mul.sv =====
// Digit-serial unsigned multiplier, one four-bit digit of the second operand per cycle.
module gste_digit_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [gste_pkg::MUL_W-1:0]     a,
	input  logic [gste_pkg::MUL_W-1:0]     b,
	output logic                           done,
	output logic [2*gste_pkg::MUL_W-1:0]   product
);

	localparam int CNT_W = $clog2(gste_pkg::MUL_STEPS + 1);
	localparam int SUM_W = gste_pkg::MUL_W + gste_pkg::DIGIT_W;

	logic [CNT_W-1:0]              cnt_q;
	logic                          done_q;
	logic [gste_pkg::MUL_W-1:0]    a_q;
	logic [gste_pkg::MUL_W-1:0]    hi_q;
	logic [gste_pkg::MUL_W-1:0]    lo_q;
	logic [SUM_W-1:0]              pp;
	logic [SUM_W-1:0]              step_sum;

	// Partial product of the low digit, added into the upper half.
	assign pp       = a_q * lo_q[gste_pkg::DIGIT_W-1:0];
	assign step_sum = SUM_W'(hi_q) + pp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(gste_pkg::MUL_STEPS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (cnt_q != '0) begin
			// The product shifts right one digit while the multiplier digits leave.
			hi_q <= step_sum[SUM_W-1:gste_pkg::DIGIT_W];
			lo_q <= {step_sum[gste_pkg::DIGIT_W-1:0],
				lo_q[gste_pkg::MUL_W-1:gste_pkg::DIGIT_W]};
		end
	end

	assign done    = done_q;
	assign product = {hi_q, lo_q};

endmodule

// ===== hw/rtl/gste_isqrt.sv =====
// Bit-serial floor square root, one root bit per cycle.
module gste_isqrt #(
	parameter int NORM_W = 27
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*NORM_W-1:0]   radicand,
	output logic                  done,
	output logic [NORM_W-1:0]     root
);

	localparam int CNT_W = $clog2(NORM_W + 1);

	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;
	logic [2*NORM_W-1:0]  rad_q;
	logic [NORM_W:0]      rem_q;
	logic [NORM_W-1:0]    root_q;
	logic [NORM_W+2:0]    rem_sh;
	logic [NORM_W+2:0]    trial;
	logic [NORM_W+2:0]    diff;
	logic                 take;

	// Bring down the next two radicand bits and try the next root bit.
	assign rem_sh = {rem_q, rad_q[2*NORM_W-1:2*NORM_W-2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign take   = (rem_sh >= trial);
	assign diff   = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NORM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[2*NORM_W-3:0], 2'b00};
			rem_q  <= take ? diff[NORM_W:0] : rem_sh[NORM_W:0];
			root_q <= {root_q[NORM_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== hw/rtl/gste_frac_div.sv =====
// Bit-serial restoring divider for a proper fraction, one quotient bit per cycle.
module gste_frac_div #(
	parameter int NORM_W = 27
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [NORM_W-1:0]             num,
	input  logic [NORM_W-1:0]             den,
	output logic                          done,
	output logic [gste_pkg::FRAC_W-1:0]   quot
);

	localparam int CNT_W = $clog2(gste_pkg::FRAC_W + 1);

	logic [CNT_W-1:0]             cnt_q;
	logic                         done_q;
	logic [NORM_W-1:0]            rem_q;
	logic [NORM_W-1:0]            den_q;
	logic [gste_pkg::FRAC_W-1:0]  quot_q;
	logic [NORM_W:0]              rem_sh;
	logic [NORM_W:0]              diff;
	logic                         take;

	// The numerator stays below the divisor, so each step needs one compare.
	assign rem_sh = {rem_q, 1'b0};
	assign take   = (rem_sh >= {1'b0, den_q});
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(gste_pkg::FRAC_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q  <= take ? diff[NORM_W-1:0] : rem_sh[NORM_W-1:0];
			quot_q <= {quot_q[gste_pkg::FRAC_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== hw/rtl/group_soft_threshold_engine_top.sv =====
// Top level of the group soft threshold engine: control, element buffer and output register.
// Sequence: a coefficient item that does not close its group is accepted, squared digit by
// digit in the multiplier and accumulated. A closing item then runs the bit-serial root, the
// quotient when the threshold is nonzero and the norm exceeds it, and the emit pass, which
// reads, scales and pushes each buffered element in turn.
// Throughput: one item at a time; the multiplier, root, divider and output stalls set it.
// Reset: arst_n clears the sum, fill count, drop mark, threshold and output valid at once.
module group_soft_threshold_engine_top #(
	parameter int GROUP_MAX = gste_pkg::GROUP_MAX_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write_en,
	input  logic [gste_pkg::THR_W-1:0]   cfg_write_data,
	gste_in_if.sink                      coefs,
	gste_out_if.source                   results
);

	// Buffer addressing and the fill count, which must also hold GROUP_MAX itself.
	localparam int IDX_W  = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;
	localparam int CNT_W  = $clog2(GROUP_MAX + 1);
	// A square is at most 2^46; the sum grows by the log of the depth.
	localparam int SUM_W  = 2 * gste_pkg::COEF_W - 1 + $clog2(GROUP_MAX);
	localparam int SQ_W   = SUM_W + (SUM_W % 2);
	localparam int NORM_W = SQ_W / 2;
	localparam int PROD_W = 2 * gste_pkg::MUL_W;

	gste_pkg::state_t state_q, state_d;

	// Element buffer with a registered read port.
	logic signed [gste_pkg::COEF_W-1:0] buffer_mem [GROUP_MAX];
	logic signed [gste_pkg::COEF_W-1:0] rd_q;

	logic [gste_pkg::THR_W-1:0]      thr_q;
	logic [SUM_W-1:0]                sum_q;
	logic [CNT_W-1:0]                fill_q;
	logic                            dropped_q;
	logic                            close_q;
	logic [CNT_W-1:0]                idx_q;
	logic [NORM_W-1:0]               norm_q;
	logic [gste_pkg::FACTOR_W-1:0]   factor_q;
	logic                            sign_q;
	logic [gste_pkg::COEF_W-1:0]     val_q;

	// Output register.
	logic                            out_valid_q;
	logic [gste_pkg::COEF_W-1:0]     out_val_q;
	logic                            out_last_q;
	logic                            out_ovf_q;

	logic                            accept;
	logic                            full;
	logic                            slot_free;
	logic                            emit_last;
	logic                            norm_gt;
	logic [NORM_W-1:0]               thr_ext;
	logic [gste_pkg::MUL_W-1:0]      in_mag;
	logic [gste_pkg::MUL_W-1:0]      rd_mag;
	logic [gste_pkg::COEF_W-1:0]     prod_mag;

	logic                            coefs_ready;
	logic                            mul_start;
	logic [gste_pkg::MUL_W-1:0]      mul_a;
	logic [gste_pkg::MUL_W-1:0]      mul_b;
	logic                            mul_done;
	logic [PROD_W-1:0]               mul_prod;
	logic                            sqrt_start;
	logic                            sqrt_done;
	logic [NORM_W-1:0]               sqrt_root;
	logic                            div_start;
	logic                            div_done;
	logic [gste_pkg::FRAC_W-1:0]     div_quot;
	logic                            out_load;

	assign accept    = coefs.valid && coefs_ready;
	assign full      = (fill_q == CNT_W'(GROUP_MAX));
	assign slot_free = !out_valid_q || results.ready;
	assign emit_last = ((idx_q + CNT_W'(1)) == fill_q);
	assign thr_ext   = NORM_W'(thr_q);
	assign norm_gt   = (norm_q > thr_ext);

	// Magnitudes of the incoming and the buffered element; the most negative code
	// maps onto 2^23, which still fits the unsigned operand.
	assign in_mag   = coefs.coefficient[gste_pkg::COEF_W-1]
		? gste_pkg::MUL_W'(-coefs.coefficient) : gste_pkg::MUL_W'(coefs.coefficient);
	assign rd_mag   = rd_q[gste_pkg::COEF_W-1]
		? gste_pkg::MUL_W'(-rd_q) : gste_pkg::MUL_W'(rd_q);
	assign prod_mag = mul_prod[gste_pkg::FRAC_W +: gste_pkg::COEF_W];

	// The multiplier is shared: it squares arriving elements and scales buffered ones.
	gste_digit_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_prod)
	);

	gste_isqrt #(
		.NORM_W (NORM_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (SQ_W'(sum_q)),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// The quotient (norm - threshold) / norm is a proper fraction when 0 < threshold < norm.
	gste_frac_div #(
		.NORM_W (NORM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (norm_q - thr_ext),
		.den    (norm_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gste_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: one item is taken in idle, then the units run in turn.
	always_comb begin
		state_d     = state_q;
		coefs_ready = 1'b0;
		mul_start   = 1'b0;
		mul_a       = in_mag;
		mul_b       = in_mag;
		sqrt_start  = 1'b0;
		div_start   = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			gste_pkg::ST_IDLE: begin
				coefs_ready = 1'b1;
				if (coefs.valid) begin
					if (!full) begin
						mul_start = 1'b1;
						state_d   = gste_pkg::ST_SQUARE;
					end else if (coefs.group_end) begin
						// A dropped element still closes the group.
						state_d = gste_pkg::ST_ROOT_GO;
					end
				end
			end
			gste_pkg::ST_SQUARE: begin
				if (mul_done) begin
					state_d = close_q ? gste_pkg::ST_ROOT_GO : gste_pkg::ST_IDLE;
				end
			end
			gste_pkg::ST_ROOT_GO: begin
				sqrt_start = 1'b1;
				state_d    = gste_pkg::ST_ROOT;
			end
			gste_pkg::ST_ROOT: begin
				if (sqrt_done) begin
					state_d = gste_pkg::ST_DECIDE;
				end
			end
			gste_pkg::ST_DECIDE: begin
				if (norm_gt && (thr_q != '0)) begin
					div_start = 1'b1;
					state_d   = gste_pkg::ST_DIVIDE;
				end else begin
					state_d = gste_pkg::ST_EMIT_READ;
				end
			end
			gste_pkg::ST_DIVIDE: begin
				if (div_done) begin
					state_d = gste_pkg::ST_EMIT_READ;
				end
			end
			gste_pkg::ST_EMIT_READ: begin
				state_d = gste_pkg::ST_EMIT_MUL;
			end
			gste_pkg::ST_EMIT_MUL: begin
				mul_start = 1'b1;
				mul_a     = rd_mag;
				mul_b     = gste_pkg::MUL_W'(factor_q);
				state_d   = gste_pkg::ST_EMIT_WAIT;
			end
			gste_pkg::ST_EMIT_WAIT: begin
				if (mul_done) begin
					state_d = gste_pkg::ST_EMIT_PUSH;
				end
			end
			gste_pkg::ST_EMIT_PUSH: begin
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = emit_last ? gste_pkg::ST_IDLE : gste_pkg::ST_EMIT_READ;
				end
			end
			default: begin
				state_d = gste_pkg::ST_IDLE;
			end
		endcase
	end

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_write_en) begin
			thr_q <= cfg_write_data;
		end
	end

	// Group state: sum of squares, fill count, drop mark and emit index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			fill_q    <= '0;
			dropped_q <= 1'b0;
			close_q   <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (accept) begin
				close_q <= coefs.group_end;
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
			if ((state_q == gste_pkg::ST_SQUARE) && mul_done) begin
				sum_q <= sum_q + SUM_W'(mul_prod);
			end
			if (state_q == gste_pkg::ST_DECIDE) begin
				idx_q <= '0;
			end
			if (out_load) begin
				idx_q <= idx_q + CNT_W'(1);
				if (emit_last) begin
					sum_q     <= '0;
					fill_q    <= '0;
					dropped_q <= 1'b0;
				end
			end
		end
	end

	// Element buffer: written at the fill count, read at the emit index.
	always_ff @(posedge clk) begin
		if (accept && !full) begin
			buffer_mem[fill_q[IDX_W-1:0]] <= coefs.coefficient;
		end
		rd_q <= buffer_mem[idx_q[IDX_W-1:0]];
	end

	// Norm, shrink factor and the scaled element.
	always_ff @(posedge clk) begin
		if (sqrt_done) begin
			norm_q <= sqrt_root;
		end
		if (state_q == gste_pkg::ST_DECIDE) begin
			// A zero threshold passes elements through; a norm at or below it zeroes them.
			factor_q <= (norm_gt && (thr_q == '0)) ? gste_pkg::ONE_Q16 : gste_pkg::ZERO_Q16;
		end
		if (div_done) begin
			factor_q <= {1'b0, div_quot};
		end
		if (state_q == gste_pkg::ST_EMIT_MUL) begin
			sign_q <= rd_q[gste_pkg::COEF_W-1];
		end
		if ((state_q == gste_pkg::ST_EMIT_WAIT) && mul_done) begin
			// Truncation toward zero: scale the magnitude, then restore the sign.
			val_q <= sign_q ? (gste_pkg::COEF_W'(0) - prod_mag) : prod_mag;
		end
	end

	// Output register: it frees the input side as soon as the last result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_val_q  <= val_q;
			out_last_q <= emit_last;
			out_ovf_q  <= dropped_q;
		end
	end

	assign coefs.ready           = coefs_ready;
	assign results.valid         = out_valid_q;
	assign results.shrunk_value  = out_val_q;
	assign results.last_of_run   = out_last_q;
	assign results.overflow_flag = out_ovf_q;

	// A result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !results.ready) |-> !out_load)
		else $error("output register overwritten while full");

	// The fill count never passes the buffer depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(GROUP_MAX))
		else $error("fill count beyond buffer depth");

	// The shared multiplier finishes only where the sequencer waits for it.
	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == gste_pkg::ST_SQUARE || state_q == gste_pkg::ST_EMIT_WAIT))
		else $error("multiplier result with no consumer");

	// The shrink factor never exceeds one during the emit pass.
	a_factor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gste_pkg::ST_EMIT_MUL) |-> (factor_q <= gste_pkg::ONE_Q16))
		else $error("shrink factor above one");

	// Loading the last result of a group empties the group state.
	a_group_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && emit_last) |=> (fill_q == '0 && sum_q == '0 && !dropped_q))
		else $error("group state not cleared after emit");

endmodule
